FILE: rtl/lscs_pkg.sv
// Package for the LRU set-associative cache simulator.
// Holds the payload structs, line-entry type, constants and codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lscs_pkg;

  // Default values for the top-level parameters
  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_MAX_WAYS     = 8;
  localparam int DEF_COUNT_WIDTH  = 32;

  localparam int ADDR_W = 64;
  // Set and block fields each take at least one bit, so a tag has at most 62 bits
  localparam int TAG_W  = ADDR_W - 2;

  // Access kinds
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_STORE  = 2'd1;
  localparam logic [1:0] FUNC_MODIFY = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] CFG_WAYS       = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [5:0] BLOCK_BITS_MAX = 6'd32;

  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic        was_hit;
    logic        was_evicted;
    logic [1:0]  hits_added;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
    logic [31:0] total_evictions;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
  } way_t;

  typedef struct packed {
    logic hit;
    logic evicted;
  } lookup_status_t;

endpackage

`default_nettype wire

FILE: rtl/lscs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lscs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lscs_way_update.sv
// Tag lookup and LRU reorder of one set row.
// Depends on lscs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lscs_way_update
  import lscs_pkg::*;
#(
  parameter int MAX_WAYS = DEF_MAX_WAYS
) (
  input  wire logic [$clog2(MAX_WAYS+1)-1:0] ways,
  input  wire logic [TAG_W-1:0]              tag,
  input  wire way_t [MAX_WAYS-1:0]           row_in,
  output way_t      [MAX_WAYS-1:0]           row_out,
  output lookup_status_t                     status
);

  localparam int WAY_IW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  way_t              ext [MAX_WAYS+1];
  logic              hit;
  logic              has_empty;
  logic [WAY_IW-1:0] hit_way;
  logic              run;
  logic              done;
  logic              filled;
  way_t              new_line;

  always_comb begin
    for (int k = 0; k < MAX_WAYS; k++) begin
      ext[k] = row_in[k];
    end
    ext[MAX_WAYS] = '0;
    new_line.valid = 1'b1;
    new_line.tag   = tag;

    hit       = 1'b0;
    has_empty = 1'b0;
    hit_way   = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (i < int'(ways)) begin
        if (row_in[i].valid) begin
          if (!hit && row_in[i].tag == tag) begin
            hit     = 1'b1;
            hit_way = WAY_IW'(i);
          end
        end else begin
          has_empty = 1'b1;
        end
      end
    end

    row_out = row_in;
    run     = 1'b0;
    done    = 1'b0;
    filled  = 1'b0;
    if (hit) begin
      // Slide the valid run above the hit way down; the hit line lands at its end
      for (int j = 0; j < MAX_WAYS; j++) begin
        if (!done && (run || int'(hit_way) == j)) begin
          run = 1'b1;
          if (j + 1 < int'(ways) && ext[j+1].valid) begin
            row_out[j].tag = ext[j+1].tag;
          end else begin
            row_out[j] = new_line;
            done       = 1'b1;
          end
        end
      end
    end else if (has_empty) begin
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (!filled && i < int'(ways) && !row_in[i].valid) begin
          row_out[i] = new_line;
          filled     = 1'b1;
        end
      end
    end else begin
      // Full set: drop way 0, shift down, new line goes last
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (i + 1 < int'(ways)) begin
          row_out[i] = ext[i+1];
        end else if (i + 1 == int'(ways)) begin
          row_out[i] = new_line;
        end
      end
    end

    status.hit     = hit;
    status.evicted = !hit && !has_empty;
  end

endmodule

`default_nettype wire

FILE: rtl/lru_set_assoc_cache_sim.sv
// Top level of the LRU set-associative cache simulator: control, config, totals.
// Depends on lscs_pkg, lscs_ram and lscs_way_update.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  --------------------------
//  access    start, busy, in_data                    taken when start && !busy
//  result    out_strobe, out_data                    one-cycle strobe, no stall
//  config    cfg_valid, cfg_ready, cfg_index, cfg_wdata  write when valid && ready
//
// An access passes through the accept edge, a READ state reading the set row from
// the line RAM, and an EVAL state comparing tags and writing the reordered row back.
// The result strobes in the cycle after EVAL, in which the next start is taken,
// so busy holds off a new access until the previous one has completed.
// Reset is synchronous; the line store needs no clearing pass, since a per-set
// flag marks rows not yet written and those read as all-invalid.
`timescale 1ns / 1ps
`default_nettype none

module lru_set_assoc_cache_sim
  import lscs_pkg::*;
#(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS,
  parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              in_data,
  output logic                       out_strobe,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int NSETS  = 1 << MAX_SET_BITS;
  localparam int ECW    = $clog2(MAX_WAYS + 1);
  localparam int SBW    = $clog2(MAX_SET_BITS + 1);
  localparam int ROW_W  = MAX_WAYS * $bits(way_t);
  localparam int CW     = COUNT_WIDTH;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [2:0]              set_bits_r;
  logic [5:0]              block_bits_r;
  logic [3:0]              ways_r;
  logic [1:0]              func_r;
  logic [MAX_SET_BITS-1:0] set_r;
  logic [TAG_W-1:0]        tag_r;
  logic [ECW-1:0]          ways_eff_r;
  logic                    row_ok_r;
  logic [NSETS-1:0]        row_valid_r;
  logic [CW-1:0]           hits_r, misses_r, evicts_r;
  logic [CW-1:0]           hits_nxt, misses_nxt, evicts_nxt;
  logic                    out_strobe_r;
  out_item_t               out_r;

  logic [SBW-1:0]          s_eff;
  logic [5:0]              b_eff;
  logic [ECW-1:0]          e_eff;
  logic [ADDR_W-1:0]       addr_shifted;
  logic [MAX_SET_BITS-1:0] set_mask;
  logic [MAX_SET_BITS-1:0] set_calc;
  logic [TAG_W-1:0]        tag_calc;
  logic                    accept;

  logic [ROW_W-1:0]        ram_rdata;
  way_t [MAX_WAYS-1:0]     row_rd;
  way_t [MAX_WAYS-1:0]     row_new;
  lookup_status_t          status;
  logic [1:0]              added;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [1:0] n);
    logic [CW:0] sum;
    sum = {1'b0, a} + (CW+1)'(n);
    return sum[CW] ? {CW{1'b1}} : sum[CW-1:0];
  endfunction

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Effective field widths and way count, clamped to their legal ranges
  always_comb begin
    if (set_bits_r == 3'd0) begin
      s_eff = SBW'(1);
    end else if (int'(set_bits_r) > MAX_SET_BITS) begin
      s_eff = SBW'(MAX_SET_BITS);
    end else begin
      s_eff = SBW'(set_bits_r);
    end
    if (block_bits_r == 6'd0) begin
      b_eff = 6'd1;
    end else if (block_bits_r > BLOCK_BITS_MAX) begin
      b_eff = BLOCK_BITS_MAX;
    end else begin
      b_eff = block_bits_r;
    end
    if (ways_r == 4'd0) begin
      e_eff = ECW'(1);
    end else if (int'(ways_r) > MAX_WAYS) begin
      e_eff = ECW'(MAX_WAYS);
    end else begin
      e_eff = ECW'(ways_r);
    end
  end

  assign addr_shifted = in_data.address >> b_eff;
  assign set_mask     = ~({MAX_SET_BITS{1'b1}} << s_eff);
  assign set_calc     = addr_shifted[MAX_SET_BITS-1:0] & set_mask;
  assign tag_calc     = TAG_W'(in_data.address >> (7'(s_eff) + 7'(b_eff)));

  lscs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NSETS)
  ) u_line_ram (
    .clk   (clk),
    .we    (state_r == ST_EVAL),
    .waddr (set_r),
    .wdata (row_new),
    .re    (state_r == ST_READ),
    .raddr (set_r),
    .rdata (ram_rdata)
  );

  // Rows never written since reset read as all-invalid
  assign row_rd = row_ok_r ? ram_rdata : '0;

  lscs_way_update #(
    .MAX_WAYS (MAX_WAYS)
  ) u_way_update (
    .ways    (ways_eff_r),
    .tag     (tag_r),
    .row_in  (row_rd),
    .row_out (row_new),
    .status  (status)
  );

  always_comb begin
    if (status.hit) begin
      added = (func_r == FUNC_MODIFY) ? 2'd2 : 2'd1;
    end else begin
      added = (func_r == FUNC_MODIFY) ? 2'd1 : 2'd0;
    end
    hits_nxt   = sat_add(hits_r, added);
    misses_nxt = status.hit ? misses_r : sat_add(misses_r, 2'd1);
    evicts_nxt = status.evicted ? sat_add(evicts_r, 2'd1) : evicts_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      set_bits_r   <= 3'd1;
      block_bits_r <= 6'd4;
      ways_r       <= 4'd1;
      row_valid_r  <= '0;
      hits_r       <= '0;
      misses_r     <= '0;
      evicts_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == ST_EVAL);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SET_BITS:   set_bits_r   <= cfg_wdata[2:0];
          CFG_BLOCK_BITS: block_bits_r <= cfg_wdata[5:0];
          CFG_WAYS:       ways_r       <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (state_r == ST_EVAL) begin
        row_valid_r[set_r] <= 1'b1;
        hits_r             <= hits_nxt;
        misses_r           <= misses_nxt;
        evicts_r           <= evicts_nxt;
      end
    end
  end

  // Transaction payload and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r     <= in_data.func;
      set_r      <= set_calc;
      tag_r      <= tag_calc;
      ways_eff_r <= e_eff;
    end
    if (state_r == ST_READ) begin
      row_ok_r <= row_valid_r[set_r];
    end
    if (state_r == ST_EVAL) begin
      out_r.was_hit         <= status.hit;
      out_r.was_evicted     <= status.evicted;
      out_r.hits_added      <= added;
      out_r.total_hits      <= 32'(hits_nxt);
      out_r.total_misses    <= 32'(misses_nxt);
      out_r.total_evictions <= 32'(evicts_nxt);
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule

`default_nettype wire

FILE: test/lscs_access_checker.sv
// Access checker for the LRU set-associative cache simulator: mirrors line store, totals
// and config, predicts each access outcome and compares every strobed result in order.
// Depends on lscs_pkg.
`timescale 1ns / 1ps

module lscs_access_checker
  import lscs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  in_item_t              in_data,
  input  logic                  out_strobe,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    outstanding
);

  localparam int NUM_SETS = 1 << DEF_MAX_SET_BITS;
  localparam int NUM_WAYS = DEF_MAX_WAYS;

  logic [63:0] shadow_tag   [NUM_SETS][NUM_WAYS];
  logic        shadow_valid [NUM_SETS][NUM_WAYS];
  logic [31:0] hit_total, miss_total, evict_total;
  logic [2:0]  set_bits_reg;
  logic [5:0]  block_bits_reg;
  logic [3:0]  ways_reg;
  out_item_t   expected_outcomes[$];
  int          results_seen;

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] result %0d: %s", $time, results_seen, msg);
  endtask

  function automatic logic [31:0] sat_add32(logic [31:0] total, logic [1:0] n);
    if (33'(total) + 33'(n) > 33'h0_FFFF_FFFF) return '1;
    return total + 32'(n);
  endfunction

  // Looks up one access in the shadow store, applies the LRU update, bumps totals.
  function automatic out_item_t lookup_and_update(in_item_t acc);
    int          s, b, e, hit_way, j;
    logic [5:0]  set_idx;
    logic [63:0] tag;
    logic        hit, evicted, has_empty;
    logic [1:0]  added;
    out_item_t   res;
    s = (set_bits_reg == 0) ? 1 :
        (set_bits_reg > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(set_bits_reg);
    b = (block_bits_reg == 0) ? 1 :
        (block_bits_reg > BLOCK_BITS_MAX) ? int'(BLOCK_BITS_MAX) : int'(block_bits_reg);
    e = (ways_reg == 0) ? 1 : (ways_reg > DEF_MAX_WAYS) ? DEF_MAX_WAYS : int'(ways_reg);
    set_idx = 6'((acc.address >> b) & ((64'd1 << s) - 64'd1));
    tag = acc.address >> (s + b);
    hit = 1'b0;
    evicted = 1'b0;
    has_empty = 1'b0;
    hit_way = 0;
    for (int i = 0; i < e; i++) begin
      if (shadow_valid[set_idx][i]) begin
        if (!hit && shadow_tag[set_idx][i] == tag) begin
          hit = 1'b1;
          hit_way = i;
        end
      end else begin
        has_empty = 1'b1;
      end
    end
    if (hit) begin
      // slide the run of valid lines above the hit down, hit goes on top
      j = hit_way;
      while (j + 1 < e && shadow_valid[set_idx][j+1]) begin
        shadow_tag[set_idx][j] = shadow_tag[set_idx][j+1];
        j++;
      end
      shadow_tag[set_idx][j] = tag;
      shadow_valid[set_idx][j] = 1'b1;
      added = (acc.func == FUNC_MODIFY) ? 2'd2 : 2'd1;
    end else begin
      miss_total = sat_add32(miss_total, 2'd1);
      if (has_empty) begin
        for (int i = 0; i < e; i++) begin
          if (!shadow_valid[set_idx][i]) begin
            shadow_tag[set_idx][i] = tag;
            shadow_valid[set_idx][i] = 1'b1;
            break;
          end
        end
      end else begin
        evicted = 1'b1;
        evict_total = sat_add32(evict_total, 2'd1);
        for (int i = 0; i + 1 < e; i++) begin
          shadow_tag[set_idx][i] = shadow_tag[set_idx][i+1];
          shadow_valid[set_idx][i] = shadow_valid[set_idx][i+1];
        end
        shadow_tag[set_idx][e-1] = tag;
        shadow_valid[set_idx][e-1] = 1'b1;
      end
      added = (acc.func == FUNC_MODIFY) ? 2'd1 : 2'd0;
    end
    hit_total = sat_add32(hit_total, added);
    res.was_hit = hit;
    res.was_evicted = evicted;
    res.hits_added = added;
    res.total_hits = hit_total;
    res.total_misses = miss_total;
    res.total_evictions = evict_total;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SETS; i++) begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          shadow_tag[i][w] = '0;
          shadow_valid[i][w] = 1'b0;
        end
      end
      hit_total = '0;
      miss_total = '0;
      evict_total = '0;
      set_bits_reg = 3'd1;
      block_bits_reg = 6'd4;
      ways_reg = 4'd1;
      expected_outcomes.delete();
      results_seen = 0;
      mismatches = 0;
      outstanding = 0;
    end else begin
      if (out_strobe) begin
        results_seen++;
        if (expected_outcomes.size() == 0) begin
          report_mismatch("result strobed with no access outstanding");
        end else begin
          want = expected_outcomes.pop_front();
          if (out_data.was_hit !== want.was_hit)
            report_mismatch($sformatf("was_hit %0d, expected %0d",
                                      out_data.was_hit, want.was_hit));
          if (out_data.was_evicted !== want.was_evicted)
            report_mismatch($sformatf("was_evicted %0d, expected %0d",
                                      out_data.was_evicted, want.was_evicted));
          if (out_data.hits_added !== want.hits_added)
            report_mismatch($sformatf("hits_added %0d, expected %0d",
                                      out_data.hits_added, want.hits_added));
          if (out_data.total_hits !== want.total_hits)
            report_mismatch($sformatf("total_hits %0d, expected %0d",
                                      out_data.total_hits, want.total_hits));
          if (out_data.total_misses !== want.total_misses)
            report_mismatch($sformatf("total_misses %0d, expected %0d",
                                      out_data.total_misses, want.total_misses));
          if (out_data.total_evictions !== want.total_evictions)
            report_mismatch($sformatf("total_evictions %0d, expected %0d",
                                      out_data.total_evictions, want.total_evictions));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SET_BITS:   set_bits_reg = cfg_wdata[2:0];
          CFG_BLOCK_BITS: block_bits_reg = cfg_wdata[5:0];
          CFG_WAYS:       ways_reg = cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (start && !busy) expected_outcomes.push_back(lookup_and_update(in_data));
      outstanding = expected_outcomes.size();
    end
  end

endmodule

FILE: test/tb_lru_set_assoc_cache_sim.sv
// Testbench top for the LRU set-associative cache simulator: clock, reset, access and
// config stimulus, verdict. Depends on lscs_pkg, the RTL and lscs_access_checker.
`timescale 1ns / 1ps

module tb_lru_set_assoc_cache_sim;
  import lscs_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int SEGMENTS      = 12;
  localparam int SEGMENT_ITEMS = 130;
  localparam logic [1:0]           FUNC_RESERVED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_data = '0;
  logic                  out_strobe;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    mismatches;
  int                    outstanding;
  int                    cycles = 0;
  int                    idle_pct = 0;
  // effective geometry, used to aim addresses at a few sets
  int                    eff_set_bits = 1;
  int                    eff_block_bits = 4;
  int                    eff_ways = 1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lru_set_assoc_cache_sim uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  lscs_access_checker access_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_strobe  (out_strobe),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("lru_set_assoc_cache_sim: mismatch");
      $finish;
    end
  end

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] compose_addr(logic [63:0] tag, logic [63:0] set_idx,
                                               logic [63:0] offset);
    return (tag << (eff_set_bits + eff_block_bits)) | (set_idx << eff_block_bits) |
           (offset & ((64'd1 << eff_block_bits) - 64'd1));
  endfunction

  // Entered and left at a falling edge with nothing yet driven in that step.
  task automatic issue_access(logic [1:0] fn, logic [63:0] addr);
    in_item_t acc;
    acc.func = fn;
    acc.address = addr;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= acc;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic quiesce();
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(logic [7:0] sb, logic [7:0] bb, logic [7:0] wy);
    quiesce();
    write_reg(CFG_SET_BITS, sb);
    write_reg(CFG_BLOCK_BITS, bb);
    write_reg(CFG_WAYS, wy);
    eff_set_bits = clamp(int'(sb[2:0]), 1, DEF_MAX_SET_BITS);
    eff_block_bits = clamp(int'(bb[5:0]), 1, int'(BLOCK_BITS_MAX));
    eff_ways = clamp(int'(wy[3:0]), 1, DEF_MAX_WAYS);
  endtask

  // Mostly a small tag pool over two hot sets, so hits and evictions both show up.
  task automatic run_segment(int n_items);
    logic [63:0] tags[$];
    logic [63:0] hot[2];
    logic [63:0] addr;
    int          pool_n, shift, k;
    shift = eff_set_bits + eff_block_bits;
    pool_n = eff_ways + $urandom_range(1, 4);
    repeat (pool_n) tags.push_back($urandom_range(1) ? 64'($urandom_range(7)) : rand64() >> shift);
    hot[0] = 64'($urandom_range((1 << eff_set_bits) - 1));
    hot[1] = 64'($urandom_range((1 << eff_set_bits) - 1));
    for (int i = 0; i < n_items; i++) begin
      k = $urandom_range(99);
      if (k < 12)
        addr = rand64();
      else if (k < 20)
        addr = compose_addr(tags[$urandom_range(pool_n - 1)],
                            64'($urandom_range((1 << eff_set_bits) - 1)), rand64());
      else
        addr = compose_addr(tags[$urandom_range(pool_n - 1)], hot[$urandom_range(1)], rand64());
      issue_access(2'($urandom_range(3)), addr);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset geometry: two sets, 16-byte blocks, direct mapped
    issue_access(FUNC_LOAD, 64'h0);
    issue_access(FUNC_LOAD, 64'h8);
    issue_access(FUNC_STORE, 64'h10);
    issue_access(FUNC_MODIFY, 64'h1F);
    issue_access(FUNC_MODIFY, 64'h20);
    issue_access(FUNC_RESERVED, 64'h20);
    issue_access(FUNC_MODIFY, '1);

    // zero in every register reads as the minimum
    configure(8'h00, 8'h00, 8'h00);
    issue_access(FUNC_LOAD, 64'h0);
    issue_access(FUNC_STORE, 64'h2);
    issue_access(FUNC_LOAD, 64'h4);
    issue_access(FUNC_MODIFY, 64'h6);

    // values past the limits saturate: 64 sets, 32 block-offset bits, 8 ways
    configure(8'h07, 8'h3F, 8'h0F);
    quiesce();
    write_reg(CFG_UNUSED, 8'hFF);
    for (int t = 0; t < 9; t++) issue_access(FUNC_STORE, compose_addr(64'(t), 64'd5, 64'd0));
    issue_access(FUNC_MODIFY, compose_addr(64'd1, 64'd5, 64'hFFFF_FFFF));
    issue_access(FUNC_LOAD, '1);

    // shrink to one way and back: leaves the same tag in two ways of a set
    configure(8'h01, 8'h04, 8'h02);
    issue_access(FUNC_LOAD, 64'h1000);
    issue_access(FUNC_LOAD, 64'h2000);
    configure(8'h01, 8'h04, 8'h01);
    issue_access(FUNC_STORE, 64'h2000);
    configure(8'h01, 8'h04, 8'h02);
    issue_access(FUNC_MODIFY, 64'h2000);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      idle_pct = (seg < SEGMENTS / 3) ? 18 : (seg < 2 * SEGMENTS / 3) ? 49 : 0;
      case (seg)
        0:       configure(8'h01, 8'h01, 8'h01);
        1:       configure(8'h06, 8'h20, 8'h08);
        2:       configure(8'h06, 8'h01, 8'h08);
        3:       configure(8'h01, 8'h20, 8'h04);
        default: configure(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      run_segment(SEGMENT_ITEMS);
    end

    quiesce();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("lru_set_assoc_cache_sim: match");
    end else begin
      $display("lru_set_assoc_cache_sim: mismatch");
    end
    $finish;
  end

endmodule
